// ----- hw/rtl/encoder_move_command_controller_top_macros.svh -----
// ============================================================================
// Encoder move command controller assertion macros
// Concurrent property wrappers, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ENCODER_MOVE_COMMAND_CONTROLLER_TOP_MACROS_SVH
`define ENCODER_MOVE_COMMAND_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define EMCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EMCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EMCC_ASSERT_IMP(lbl, ante, cons, msg)

`define EMCC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/emcc_pkg.sv -----
// ============================================================================
// Encoder move command controller package
// Shared types and codes for the frame parser and move control.
// ============================================================================
`default_nettype none

package emcc_pkg;

    localparam int FRAME_W   = 7;
    localparam int VALUE_W   = 16;
    localparam int DIR_W     = 4;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MM_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEG_FACTOR = 2'd1;

    localparam logic [15:0] MM_FACTOR_RESET  = 16'd12277;
    localparam logic [15:0] DEG_FACTOR_RESET = 16'd16023;

    // request kinds
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_LEFT  = 2'd1;
    localparam logic [1:0] CMD_RIGHT = 2'd2;

    // move modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_TURN   = 2'd2;

    // frame bytes
    localparam logic [7:0] BYTE_TERM  = 8'h28;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] CHAR_FWD   = 8'h31;
    localparam logic [7:0] CHAR_BACK  = 8'h32;
    localparam logic [7:0] CHAR_LEFT  = 8'h33;
    localparam logic [7:0] CHAR_RIGHT = 8'h34;
    localparam logic [7:0] CHAR_SL_A  = 8'h35;
    localparam logic [7:0] CHAR_SL_B  = 8'h36;
    localparam logic [7:0] CHAR_SL_C  = 8'h37;
    localparam logic [7:0] CHAR_SL_D  = 8'h38;
    localparam logic [7:0] CHAR_STOP  = 8'h39;

    // motor direction nibbles
    localparam logic [DIR_W-1:0] DIR_STOP  = 4'h0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 4'h6;
    localparam logic [DIR_W-1:0] DIR_BACK  = 4'h9;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 4'h5;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 4'hA;
    localparam logic [DIR_W-1:0] DIR_SL_A  = 4'h4;
    localparam logic [DIR_W-1:0] DIR_SL_B  = 4'h2;
    localparam logic [DIR_W-1:0] DIR_SL_C  = 4'h1;
    localparam logic [DIR_W-1:0] DIR_SL_D  = 4'h8;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_len;
        logic [7:0]         command_char;
        logic [VALUE_W-1:0] value_accum;
        logic               digits_ended;
        logic [1:0]         move_mode;
        logic [VALUE_W-1:0] target;
        logic [VALUE_W-1:0] left_ticks;
        logic [VALUE_W-1:0] right_ticks;
        logic [DIR_W-1:0]   dir;
    } state_t;

    typedef struct packed {
        logic [DIR_W-1:0]   motor_dir;
        logic               moving;
        logic               move_done;
        logic [VALUE_W-1:0] target_count;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/emcc_step.sv -----
// ============================================================================
// Encoder move command step logic
// Next state and result for one request: frame parse, decode, tick stop.
// ============================================================================
`default_nettype none

module emcc_step #(
    parameter int MAX_FRAME = 99
) (
    input  wire emcc_pkg::state_t  st,
    input  wire logic [1:0]        cmd,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [15:0]       mm_factor,
    input  wire logic [15:0]       deg_factor,
    output      emcc_pkg::state_t  st_next,
    output      emcc_pkg::result_t res
);

    localparam logic [emcc_pkg::FRAME_W-1:0] FRAME_MAX =
        emcc_pkg::FRAME_W'(MAX_FRAME);
    localparam logic [emcc_pkg::VALUE_W-1:0] CNT_MAX = '1;

    logic                          is_digit;
    logic [19:0]                   acc_ext;
    logic [7:0]                    cmd_eff;
    logic                          is_linear;
    logic                          is_soft;
    logic [emcc_pkg::VALUE_W-1:0]  mul_a;
    logic [15:0]                   mul_b;
    logic [31:0]                   product;
    logic [emcc_pkg::VALUE_W-1:0]  scaled;
    logic                          hit;
    logic                          done;

    assign is_digit = (rx_byte >= emcc_pkg::BYTE_ZERO) && (rx_byte <= emcc_pkg::BYTE_NINE);
    assign acc_ext  = {4'd0, st.value_accum} * 20'd10 + {12'd0, rx_byte - emcc_pkg::BYTE_ZERO};

    assign cmd_eff   = (st.frame_len == '0) ? rx_byte : st.command_char;
    assign is_linear = (cmd_eff == emcc_pkg::CHAR_FWD) || (cmd_eff == emcc_pkg::CHAR_BACK);
    assign is_soft   = (cmd_eff == emcc_pkg::CHAR_SL_A) || (cmd_eff == emcc_pkg::CHAR_SL_B)
                    || (cmd_eff == emcc_pkg::CHAR_SL_C) || (cmd_eff == emcc_pkg::CHAR_SL_D);
    assign mul_a     = is_soft ? {st.value_accum[emcc_pkg::VALUE_W-2:0], 1'b0} : st.value_accum;
    assign mul_b     = is_linear ? mm_factor : deg_factor;
    assign product   = {16'd0, mul_a} * {16'd0, mul_b};
    assign scaled    = product[31:16];

    always_comb
    begin
        st_next = st;
        hit     = 1'b0;
        done    = 1'b0;
        case (cmd)
            emcc_pkg::CMD_BYTE:
            begin
                if (st.move_mode == emcc_pkg::MODE_IDLE)
                begin
                    if (st.frame_len == '0)
                    begin
                        st_next.command_char = rx_byte;
                        st_next.frame_len    = emcc_pkg::FRAME_W'(1);
                    end
                    else if (st.frame_len < FRAME_MAX)
                    begin
                        st_next.frame_len = st.frame_len + emcc_pkg::FRAME_W'(1);
                        if (!st.digits_ended)
                        begin
                            if (is_digit)
                                st_next.value_accum = (acc_ext > 20'hFFFF) ? CNT_MAX
                                                                           : acc_ext[15:0];
                            else
                                st_next.digits_ended = 1'b1;
                        end
                    end
                    if (rx_byte == emcc_pkg::BYTE_TERM)
                    begin
                        st_next.frame_len    = '0;
                        st_next.command_char = '0;
                        st_next.value_accum  = '0;
                        st_next.digits_ended = 1'b0;
                        case (cmd_eff)
                            emcc_pkg::CHAR_FWD, emcc_pkg::CHAR_BACK:
                            begin
                                st_next.dir = (cmd_eff == emcc_pkg::CHAR_FWD)
                                              ? emcc_pkg::DIR_FWD : emcc_pkg::DIR_BACK;
                                st_next.target      = scaled;
                                st_next.right_ticks = '0;
                                st_next.move_mode   = emcc_pkg::MODE_LINEAR;
                            end
                            emcc_pkg::CHAR_LEFT, emcc_pkg::CHAR_RIGHT,
                            emcc_pkg::CHAR_SL_A, emcc_pkg::CHAR_SL_B,
                            emcc_pkg::CHAR_SL_C, emcc_pkg::CHAR_SL_D:
                            begin
                                case (cmd_eff)
                                    emcc_pkg::CHAR_LEFT:  st_next.dir = emcc_pkg::DIR_LEFT;
                                    emcc_pkg::CHAR_RIGHT: st_next.dir = emcc_pkg::DIR_RIGHT;
                                    emcc_pkg::CHAR_SL_A:  st_next.dir = emcc_pkg::DIR_SL_A;
                                    emcc_pkg::CHAR_SL_B:  st_next.dir = emcc_pkg::DIR_SL_B;
                                    emcc_pkg::CHAR_SL_C:  st_next.dir = emcc_pkg::DIR_SL_C;
                                    default:              st_next.dir = emcc_pkg::DIR_SL_D;
                                endcase
                                st_next.target      = scaled;
                                st_next.left_ticks  = '0;
                                st_next.right_ticks = '0;
                                st_next.move_mode   = emcc_pkg::MODE_TURN;
                                // zero target: stop at once
                                if (scaled == '0)
                                begin
                                    st_next.dir       = emcc_pkg::DIR_STOP;
                                    st_next.move_mode = emcc_pkg::MODE_IDLE;
                                    done              = 1'b1;
                                end
                            end
                            emcc_pkg::CHAR_STOP:
                            begin
                                st_next.dir = emcc_pkg::DIR_STOP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            emcc_pkg::CMD_LEFT, emcc_pkg::CMD_RIGHT:
            begin
                if (cmd == emcc_pkg::CMD_LEFT)
                begin
                    if (st.left_ticks != CNT_MAX)
                        st_next.left_ticks = st.left_ticks + emcc_pkg::VALUE_W'(1);
                end
                else
                begin
                    if (st.right_ticks != CNT_MAX)
                        st_next.right_ticks = st.right_ticks + emcc_pkg::VALUE_W'(1);
                end
                if (st.move_mode == emcc_pkg::MODE_LINEAR)
                    hit = st_next.right_ticks > st.target;
                else if (st.move_mode == emcc_pkg::MODE_TURN)
                    hit = (st_next.right_ticks >= st.target) || (st_next.left_ticks >= st.target);
                if (hit)
                begin
                    st_next.dir       = emcc_pkg::DIR_STOP;
                    st_next.move_mode = emcc_pkg::MODE_IDLE;
                    done              = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.motor_dir    = st_next.dir;
    assign res.moving       = (st_next.move_mode != emcc_pkg::MODE_IDLE);
    assign res.move_done    = done;
    assign res.target_count = st_next.target;

endmodule

`default_nettype wire

// ----- hw/rtl/encoder_move_command_controller_top.sv -----
// ============================================================================
// Encoder move command controller
// Requests are held in the input register, their results in the result register.
// One request per cycle while the output is not stalled; the input and result
// registers part the channels; the state updates in one pass of the step logic.
// Reset clears frame, move and tick state and loads the factor registers.
// ============================================================================
`default_nettype none
`include "encoder_move_command_controller_top_macros.svh"

module encoder_move_command_controller_top #(
    parameter int MAX_FRAME = 99
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic [1:0]                     cmd,
    input  wire logic [7:0]                     rx_byte,
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic [emcc_pkg::DIR_W-1:0]     motor_dir,
    output      logic                           moving,
    output      logic                           move_done,
    output      logic [emcc_pkg::VALUE_W-1:0]   target_count,
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [emcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data
);

    logic              in_valid_reg;
    logic [1:0]        cmd_reg;
    logic [7:0]        byte_reg;
    logic              out_valid_reg;
    emcc_pkg::result_t res_reg;
    emcc_pkg::result_t res_next;
    emcc_pkg::state_t  state_reg;
    emcc_pkg::state_t  state_next;
    logic [15:0]       mm_factor_reg;
    logic [15:0]       deg_factor_reg;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    emcc_step #(
        .MAX_FRAME (MAX_FRAME)
    ) u_step (
        .st         (state_reg),
        .cmd        (cmd_reg),
        .rx_byte    (byte_reg),
        .mm_factor  (mm_factor_reg),
        .deg_factor (deg_factor_reg),
        .st_next    (state_next),
        .res        (res_next)
    );

    // hold the accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            byte_reg <= rx_byte;
        end
    end

    // advance state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_factor_reg  <= emcc_pkg::MM_FACTOR_RESET;
            deg_factor_reg <= emcc_pkg::DEG_FACTOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == emcc_pkg::REG_MM_FACTOR)
                mm_factor_reg <= cfg_data;
            else if (cfg_index == emcc_pkg::REG_DEG_FACTOR)
                deg_factor_reg <= cfg_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign motor_dir    = res_reg.motor_dir;
    assign moving       = res_reg.moving;
    assign move_done    = res_reg.move_done;
    assign target_count = res_reg.target_count;

    `EMCC_ASSERT_IMP(a_done_stopped, out_valid && move_done, !moving && (motor_dir == emcc_pkg::DIR_STOP), "finished move still driving")
    `EMCC_ASSERT_IMP(a_moving_dir, state_reg.move_mode != emcc_pkg::MODE_IDLE, state_reg.dir != emcc_pkg::DIR_STOP, "move in progress with motors stopped")
    `EMCC_ASSERT_NXT(a_drop_bytes, advance && (cmd_reg == emcc_pkg::CMD_BYTE) && (state_reg.move_mode != emcc_pkg::MODE_IDLE), $stable(state_reg), "byte changed state while moving")
    `EMCC_ASSERT_NXT(a_target_hold, !advance, $stable(state_reg.target), "target changed without a request")

endmodule

`default_nettype wire
